/* design/jpid_pkg.sv */
package jpid_pkg;

    // Field and register widths
    localparam int ANGLE_W     = 16;
    localparam int RATE_W      = 20;
    localparam int TORQUE_W    = 20;
    localparam int GAIN_W      = 16;
    localparam int BOUND_W     = 15;
    localparam int LIMIT_W     = 19;

    // Configuration write channel
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 19;

    // Integral-term divide by 2000 runs one 17-bit digit per step
    localparam int NUM_DIGITS  = 3;
    localparam int DIGIT_CNT_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN    = 3'd0,
        REG_DERIV_GAIN   = 3'd1,
        REG_INTEG_GAIN   = 3'd2,
        REG_ERROR_BOUND  = 3'd3,
        REG_TORQUE_LIMIT = 3'd4
    } jpid_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE_SUM,
        ST_RATE_DIV,
        ST_PROP,
        ST_DERIV,
        ST_CHECK,
        ST_INTEG,
        ST_ITQ,
        ST_DIV,
        ST_OUT
    } jpid_state_t;

    // Datapath commands, one strobe per step of the sample sequence
    typedef struct packed {
        logic load;
        logic rate_sum;
        logic rate_div;
        logic prop;
        logic deriv;
        logic check;
        logic integ;
        logic itq;
        logic div_step;
        logic out_load;
    } jpid_cmd_t;

endpackage

/* design/jpid_if.sv */
interface jpid_sample_if;
    import jpid_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] measured_angle;
    logic signed [ANGLE_W-1:0] desired_angle;
    logic signed [RATE_W-1:0]  desired_rate;

    modport source (output valid, output measured_angle, output desired_angle,
                    output desired_rate, input ready);
    modport sink   (input valid, input measured_angle, input desired_angle,
                    input desired_rate, output ready);
endinterface

interface jpid_result_if;
    import jpid_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [TORQUE_W-1:0] torque;
    logic                       integ_cleared;

    modport source (output valid, output torque, output integ_cleared, input ready);
    modport sink   (input valid, input torque, input integ_cleared, output ready);
endinterface

interface jpid_cfg_if;
    import jpid_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/jpid_datapath.sv */
module jpid_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  jpid_pkg::jpid_cmd_t                 cmd,
    input  logic                                cfg_we,
    input  logic [jpid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [jpid_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [jpid_pkg::ANGLE_W-1:0] measured_angle,
    input  logic signed [jpid_pkg::ANGLE_W-1:0] desired_angle,
    input  logic signed [jpid_pkg::RATE_W-1:0]  desired_rate,
    output logic signed [jpid_pkg::TORQUE_W-1:0] torque,
    output logic                                integ_cleared
);
    import jpid_pkg::*;

    localparam int ERR_W   = ANGLE_W + 1;
    localparam int RERR_W  = RATE_W + 1;
    localparam int RAW_W   = ERR_W + 11;
    localparam int SUM_W   = 22;
    localparam int D3P_W   = 45;
    localparam int ACC_W   = 38;
    localparam int PD_W    = 30;
    localparam int INTEG_W = 32;
    localparam int ISUM_W  = INTEG_W + 2;
    localparam int KPROD_W = INTEG_W + GAIN_W + 1;
    localparam int Z_W     = 51;
    localparam int DIGIT_W = 17;
    localparam int REM_W   = 11;
    localparam int V_W     = REM_W + DIGIT_W;
    localparam int DP_W    = 58;
    localparam int QUO_W   = 38;
    localparam int WIDE_W  = 40;

    localparam logic signed [10:0]       RAW_SCALE = 11'sd1000;
    // Offset of 3 * 2^19 makes the three-term rate sum non-negative
    localparam logic [SUM_W-1:0]         SUM_OFS   = 22'd1572864;
    // ceil(2^24 / 3): exact floor divide for sums below 2^23
    localparam logic [22:0]              DIV3_MUL  = 23'd5592406;
    // 1000 for rounding plus 2000 * 2^37 to keep the dividend positive
    localparam logic [Z_W-1:0]           ITQ_BIAS  = 51'd274877906945000;
    // ceil(2^40 / 2000): exact per-digit quotient for partial dividends below 2^28
    localparam logic [29:0]              DIV2K_MUL = 30'd549755814;
    localparam logic signed [WIDE_W-1:0] ITQ_OFS   = 40'sh20_0000_0000;
    localparam logic signed [WIDE_W-1:0] RATE_MAX  = 40'sd524287;
    localparam logic signed [WIDE_W-1:0] RATE_MIN  = -40'sd524288;
    localparam logic signed [WIDE_W-1:0] INTEG_MAX = 40'sd2147483647;
    localparam logic signed [WIDE_W-1:0] INTEG_MIN = -40'sd2147483648;

    function automatic logic signed [RATE_W-1:0] sat_rate(input logic signed [WIDE_W-1:0] v);
        if (v > RATE_MAX)
            sat_rate = RATE_MAX[RATE_W-1:0];
        else if (v < RATE_MIN)
            sat_rate = RATE_MIN[RATE_W-1:0];
        else
            sat_rate = v[RATE_W-1:0];
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat_integ(input logic signed [WIDE_W-1:0] v);
        if (v > INTEG_MAX)
            sat_integ = INTEG_MAX[INTEG_W-1:0];
        else if (v < INTEG_MIN)
            sat_integ = INTEG_MIN[INTEG_W-1:0];
        else
            sat_integ = v[INTEG_W-1:0];
    endfunction

    // Configuration and loop state
    logic [GAIN_W-1:0]          prop_gain_reg;
    logic [GAIN_W-1:0]          deriv_gain_reg;
    logic [GAIN_W-1:0]          integ_gain_reg;
    logic [BOUND_W-1:0]         error_bound_reg;
    logic [LIMIT_W-1:0]         torque_limit_reg;
    logic signed [ANGLE_W-1:0]  last_angle_reg;
    logic signed [RATE_W-1:0]   rate_hist_one_reg;
    logic signed [RATE_W-1:0]   rate_hist_two_reg;
    logic signed [ERR_W-1:0]    last_error_reg;
    logic signed [INTEG_W-1:0]  integ_sum_reg;

    // Per-sample working registers
    logic signed [ANGLE_W-1:0]  meas_reg;
    logic signed [RATE_W-1:0]   want_rate_reg;
    logic signed [RATE_W-1:0]   raw_reg;
    logic signed [ERR_W-1:0]    err_reg;
    logic [SUM_W-1:0]           sum_reg;
    logic signed [RERR_W-1:0]   rerr_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [PD_W-1:0]     pd_reg;
    logic                       clear_reg;
    logic [Z_W-1:0]             z_reg;
    logic [REM_W-1:0]           rem_reg;
    logic [QUO_W-1:0]           quo_reg;
    logic signed [TORQUE_W-1:0] torque_reg;
    logic                       cleared_reg;

    logic signed [ERR_W-1:0]    angle_diff;
    logic signed [RAW_W-1:0]    raw_prod;
    logic signed [RATE_W-1:0]   raw_next;
    logic signed [ERR_W-1:0]    err_next;
    logic [SUM_W-1:0]           sum_next;
    logic [D3P_W-1:0]           div3_prod;
    logic [RATE_W-1:0]          rate_quo;
    logic signed [RATE_W-1:0]   rate_next;
    logic signed [RERR_W-1:0]   rerr_next;
    logic signed [33:0]         prop_term;
    logic signed [ACC_W-1:0]    deriv_term;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [PD_W-1:0]     pd_next;
    logic [PD_W-1:0]            pd_abs;
    logic [ERR_W-1:0]           err_abs;
    logic                       clear_next;
    logic signed [ISUM_W-1:0]   integ_wide;
    logic signed [INTEG_W-1:0]  integ_next;
    logic signed [KPROD_W-1:0]  ki_prod;
    logic [V_W-1:0]             part_div;
    logic [DP_W-1:0]            digit_prod;
    logic [DIGIT_W-1:0]         digit_quo;
    logic [V_W-1:0]             digit_back;
    logic [V_W-1:0]             rem_full;
    logic [Z_W-1:0]             z_next;
    logic [REM_W-1:0]           rem_next;
    logic [QUO_W-1:0]           quo_next;
    logic signed [WIDE_W-1:0]   itq;
    logic signed [WIDE_W-1:0]   torque_wide;
    logic signed [TORQUE_W-1:0] torque_next;

    // Load step: backward difference scaled to rad/s and the angle error
    assign angle_diff = $signed({measured_angle[ANGLE_W-1], measured_angle})
                      - $signed({last_angle_reg[ANGLE_W-1], last_angle_reg});
    assign raw_prod   = angle_diff * RAW_SCALE;
    assign raw_next   = sat_rate($signed({{(WIDE_W-RAW_W){raw_prod[RAW_W-1]}}, raw_prod}));
    assign err_next   = $signed({desired_angle[ANGLE_W-1], desired_angle})
                      - $signed({measured_angle[ANGLE_W-1], measured_angle});

    // Three-tap average, offset into the unsigned range
    assign sum_next = {{(SUM_W-RATE_W){raw_reg[RATE_W-1]}}, raw_reg}
                    + {{(SUM_W-RATE_W){rate_hist_one_reg[RATE_W-1]}}, rate_hist_one_reg}
                    + {{(SUM_W-RATE_W){rate_hist_two_reg[RATE_W-1]}}, rate_hist_two_reg}
                    + SUM_OFS;

    // Floor divide by 3; removing the 2^19 offset flips the top bit
    assign div3_prod = sum_reg * DIV3_MUL;
    assign rate_quo  = div3_prod[43:24];
    assign rate_next = $signed({~rate_quo[RATE_W-1], rate_quo[RATE_W-2:0]});

    assign rerr_next = $signed({want_rate_reg[RATE_W-1], want_rate_reg})
                     - $signed({rate_hist_one_reg[RATE_W-1], rate_hist_one_reg});

    assign prop_term  = $signed({1'b0, prop_gain_reg}) * err_reg;
    assign deriv_term = $signed({1'b0, deriv_gain_reg}) * rerr_reg;

    always_comb
    begin
        if (cmd.prop)
            acc_next = $signed({{(ACC_W-34){prop_term[33]}}, prop_term});
        else
            acc_next = acc_reg + deriv_term + 38'sd128;
    end

    // PD torque with half-up rounding, then the clear decision
    assign pd_next    = $signed(acc_reg[ACC_W-1:8]);
    assign pd_abs     = pd_next[PD_W-1] ? (~pd_next + 1'b1) : pd_next;
    assign err_abs    = err_reg[ERR_W-1] ? (~err_reg + 1'b1) : err_reg;
    assign clear_next = (pd_abs > PD_W'(torque_limit_reg))
                     || (err_abs > ERR_W'(error_bound_reg));

    // Trapezoidal accumulate
    assign integ_wide = $signed({{2{integ_sum_reg[INTEG_W-1]}}, integ_sum_reg})
                      + $signed({{(ISUM_W-ERR_W){err_reg[ERR_W-1]}}, err_reg})
                      + $signed({{(ISUM_W-ERR_W){last_error_reg[ERR_W-1]}}, last_error_reg});
    assign integ_next = clear_reg ? '0
                      : sat_integ($signed({{(WIDE_W-ISUM_W){integ_wide[ISUM_W-1]}},
                                            integ_wide}));

    assign ki_prod = $signed({1'b0, integ_gain_reg}) * integ_sum_reg;

    // One digit of the divide by 2000; 2000*q is built from shifts
    assign part_div   = {rem_reg, z_reg[Z_W-1 -: DIGIT_W]};
    assign digit_prod = part_div * DIV2K_MUL;
    assign digit_quo  = digit_prod[56:40];
    assign digit_back = {digit_quo, 11'b0} - V_W'({digit_quo, 5'b0}) - V_W'({digit_quo, 4'b0});
    assign rem_full   = part_div - digit_back;

    always_comb
    begin
        if (cmd.itq)
        begin
            z_next   = {{(Z_W-KPROD_W){ki_prod[KPROD_W-1]}}, ki_prod} + ITQ_BIAS;
            rem_next = '0;
            quo_next = '0;
        end
        else
        begin
            z_next   = {z_reg[Z_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
            rem_next = rem_full[REM_W-1:0];
            quo_next = {quo_reg[QUO_W-DIGIT_W-1:0], digit_quo};
        end
    end

    assign itq         = $signed({2'b00, quo_reg}) - ITQ_OFS;
    assign torque_wide = $signed({{(WIDE_W-PD_W){pd_reg[PD_W-1]}}, pd_reg}) + itq;
    assign torque_next = sat_rate(torque_wide);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= 16'd12800;
            deriv_gain_reg    <= 16'd512;
            integ_gain_reg    <= 16'd400;
            error_bound_reg   <= 15'd205;
            torque_limit_reg  <= 19'd20480;
            last_angle_reg    <= '0;
            rate_hist_one_reg <= '0;
            rate_hist_two_reg <= '0;
            last_error_reg    <= '0;
            integ_sum_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_PROP_GAIN:    prop_gain_reg    <= cfg_data[GAIN_W-1:0];
                    REG_DERIV_GAIN:   deriv_gain_reg   <= cfg_data[GAIN_W-1:0];
                    REG_INTEG_GAIN:   integ_gain_reg   <= cfg_data[GAIN_W-1:0];
                    REG_ERROR_BOUND:  error_bound_reg  <= cfg_data[BOUND_W-1:0];
                    REG_TORQUE_LIMIT: torque_limit_reg <= cfg_data[LIMIT_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.rate_div)
            begin
                last_angle_reg    <= meas_reg;
                rate_hist_two_reg <= rate_hist_one_reg;
                rate_hist_one_reg <= rate_next;
            end
            if (cmd.integ)
            begin
                integ_sum_reg  <= integ_next;
                last_error_reg <= err_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            meas_reg      <= measured_angle;
            want_rate_reg <= desired_rate;
            raw_reg       <= raw_next;
            err_reg       <= err_next;
        end
        if (cmd.rate_sum)
            sum_reg <= sum_next;
        if (cmd.prop)
            rerr_reg <= rerr_next;
        if (cmd.prop || cmd.deriv)
            acc_reg <= acc_next;
        if (cmd.check)
        begin
            pd_reg    <= pd_next;
            clear_reg <= clear_next;
        end
        if (cmd.itq || cmd.div_step)
        begin
            z_reg   <= z_next;
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
        if (cmd.out_load)
        begin
            torque_reg  <= torque_next;
            cleared_reg <= clear_reg;
        end
    end

    assign torque        = torque_reg;
    assign integ_cleared = cleared_reg;

endmodule

/* design/jpid_controller.sv */
module jpid_controller (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                out_ready,
    output logic                out_valid,
    output jpid_pkg::jpid_cmd_t cmd
);
    import jpid_pkg::*;

    localparam logic [DIGIT_CNT_W-1:0] LAST_DIGIT = DIGIT_CNT_W'(NUM_DIGITS - 1);

    jpid_state_t             state_reg;
    jpid_state_t             state_next;
    logic [DIGIT_CNT_W-1:0]  digit_cnt_reg;
    logic [DIGIT_CNT_W-1:0]  digit_cnt_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic                    out_free;

    // Result slot can take a new value when empty or being drained
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = ST_RATE_SUM;
            ST_RATE_SUM: state_next = ST_RATE_DIV;
            ST_RATE_DIV: state_next = ST_PROP;
            ST_PROP:     state_next = ST_DERIV;
            ST_DERIV:    state_next = ST_CHECK;
            ST_CHECK:    state_next = ST_INTEG;
            ST_INTEG:    state_next = ST_ITQ;
            ST_ITQ:      state_next = ST_DIV;
            ST_DIV:      if (digit_cnt_reg == LAST_DIGIT) state_next = ST_OUT;
            ST_OUT:      if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_RATE_SUM: cmd.rate_sum = 1'b1;
            ST_RATE_DIV: cmd.rate_div = 1'b1;
            ST_PROP:     cmd.prop     = 1'b1;
            ST_DERIV:    cmd.deriv    = 1'b1;
            ST_CHECK:    cmd.check    = 1'b1;
            ST_INTEG:    cmd.integ    = 1'b1;
            ST_ITQ:      cmd.itq      = 1'b1;
            ST_DIV:      cmd.div_step = 1'b1;
            ST_OUT:      cmd.out_load = out_free;
            default:     ;
        endcase
    end

    assign digit_cnt_next = (state_reg == ST_DIV && digit_cnt_reg != LAST_DIGIT)
                          ? digit_cnt_reg + 1'b1 : '0;
    assign out_valid_next = cmd.out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            digit_cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            digit_cnt_reg <= digit_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_RATE_SUM)
        else $error("accepted sample did not start the sequence");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("result register overwritten while still held");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_digit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_DIV |-> digit_cnt_reg == '0)
        else $error("digit counter running outside the divide");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV && digit_cnt_reg == LAST_DIGIT |=> state_reg == ST_OUT)
        else $error("divide did not finish after the last digit");
`endif

endmodule

/* design/joint_pid_with_velocity_filter_unit.sv */
// Channel  Role   Handshake      Payload
// sample   sink   valid/ready    measured_angle, desired_angle, desired_rate
// result   source valid/ready    torque, integ_cleared
// cfg      sink   valid/ready    index, data (ready held high)
//
// One sample item passes through the accept cycle, seven datapath steps,
// a three-digit divide by 2000 for the integral term and the output load.
// A finished result waits in the output register; the next sample is taken while
// it waits, and the sequence stalls only at its last step if the result is still held.
// Reset (rst_n, async low) restores the default gains and limits and zeroes the
// angle, rate history, error and integrator state.
module joint_pid_with_velocity_filter_unit (
    input logic           clk,
    input logic           rst_n,
    jpid_sample_if.sink   sample,
    jpid_result_if.source result,
    jpid_cfg_if.sink      cfg
);
    import jpid_pkg::*;

    jpid_cmd_t cmd;
    logic      sample_ready;
    logic      result_valid;

    // Register writes land immediately; the datapath is idle by contract
    assign cfg.ready = 1'b1;

    // Sequencer: walks one sample through the datapath steps and owns
    // the result valid flag.
    jpid_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample_ready),
        .out_ready (result.ready),
        .out_valid (result_valid),
        .cmd       (cmd)
    );

    // Datapath: velocity filter, PD sum, integrator with clear, divide by
    // 2000 and output saturation, plus the configuration registers.
    jpid_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .cfg_we         (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .measured_angle (sample.measured_angle),
        .desired_angle  (sample.desired_angle),
        .desired_rate   (sample.desired_rate),
        .torque         (result.torque),
        .integ_cleared  (result.integ_cleared)
    );

    assign sample.ready = sample_ready;
    assign result.valid = result_valid;

endmodule

/* sim/tb_joint_pid_with_velocity_filter_unit.sv */
`timescale 1ns / 100ps

module tb_joint_pid_with_velocity_filter_unit;
    import jpid_pkg::*;

    // Run limits: about 550 items plus idle bursts and result stalls
    // stay well below this.
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 20;
    localparam int WINDUP_ITEMS    = 20;
    localparam int ITEMS_PER_PHASE = 84;
    localparam int RANDOM_PHASES   = 6;

    // Indexes past the register file; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_MID = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI  = 3'd7;

    typedef struct {
        logic signed [ANGLE_W-1:0] measured_angle;
        logic signed [ANGLE_W-1:0] desired_angle;
        logic signed [RATE_W-1:0]  desired_rate;
        logic                      drain_first;  // hold this item until all results are in
    } sample_t;

    typedef struct {
        logic signed [TORQUE_W-1:0] torque;
        logic                       integ_cleared;
    } torque_t;

    logic clk = 1'b0;
    logic rst_n;

    jpid_sample_if sample_bus();
    jpid_result_if result_bus();
    jpid_cfg_if    cfg_bus();

    joint_pid_with_velocity_filter_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_bus),
        .result (result_bus),
        .cfg    (cfg_bus)
    );

    // Clock: 8 ns period
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Stimulus and scoreboard storage
    sample_t pending_samples[$];
    torque_t expected_torques[$];

    logic sample_taken = 1'b0;  // sample handshake seen at the last rising edge
    logic cfg_taken    = 1'b0;  // config handshake seen at the last rising edge
    logic idle_on      = 1'b0;  // enable random idle bursts on both sides
    int   send_gap     = 0;
    int   stall_left   = 0;
    int   fail_count   = 0;
    int   cycle_count  = 0;

    // Shadow registers, loaded only on accepted config writes
    logic [GAIN_W-1:0]  kp_shadow = 16'd12800;
    logic [GAIN_W-1:0]  kd_shadow = 16'd512;
    logic [GAIN_W-1:0]  ki_shadow = 16'd400;
    logic [BOUND_W-1:0] eb_shadow = 15'd205;
    logic [LIMIT_W-1:0] tl_shadow = 19'd20480;

    // Controller state as the block should hold it
    logic signed [ANGLE_W-1:0] prev_angle  = '0;
    logic signed [RATE_W-1:0]  rate_hist_a = '0;
    logic signed [RATE_W-1:0]  rate_hist_b = '0;
    logic signed [ANGLE_W:0]   prev_error  = '0;
    logic signed [31:0]        integ_acc   = '0;

    // Saturate to a w-bit signed range
    function automatic longint clip_signed(input longint v, input int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // Division rounding toward minus infinity, b > 0
    function automatic longint div_floor(input longint a, input longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0)
            q = q - 1;
        return q;
    endfunction

    // Advance the controller state by one sample and return the torque it commands
    function automatic torque_t predict_torque(input sample_t s);
        longint  meas;
        longint  raw;
        longint  rate;
        longint  err;
        longint  rate_err;
        longint  pd;
        longint  itq;
        logic    clr;
        torque_t r;
        meas = longint'(s.measured_angle);
        // Backward difference times 1000, then a three-tap average with floor
        raw  = clip_signed((meas - prev_angle) * 1000, RATE_W);
        rate = div_floor(raw + rate_hist_a + rate_hist_b, 3);
        err      = s.desired_angle - meas;
        rate_err = s.desired_rate - rate;
        // PD term in Q8.F, rounded half up from the Q8.8 gain products
        pd = div_floor(longint'(kp_shadow) * err + longint'(kd_shadow) * rate_err + 128, 256);
        // Clear the integrator on a large PD torque or a large error (strict compare)
        clr = ((pd < 0 ? -pd : pd) > longint'(tl_shadow)) ||
              ((err < 0 ? -err : err) > longint'(eb_shadow));
        if (clr)
            integ_acc = '0;
        else
            integ_acc = 32'(clip_signed(longint'(integ_acc) + err + longint'(prev_error), 32));
        itq = div_floor(longint'(ki_shadow) * longint'(integ_acc) + 1000, 2000);
        r.torque        = TORQUE_W'(clip_signed(pd + itq, TORQUE_W));
        r.integ_cleared = clr;
        prev_angle  = s.measured_angle;
        rate_hist_b = rate_hist_a;
        rate_hist_a = RATE_W'(rate);
        prev_error  = (ANGLE_W + 1)'(err);
        return r;
    endfunction

    // Monitor: sample all three channels at the rising edge
    always @(posedge clk)
    begin : watch_channels
        sample_t got;
        torque_t want;
        sample_taken <= sample_bus.valid && sample_bus.ready;
        cfg_taken    <= cfg_bus.valid && cfg_bus.ready;
        if (rst_n)
        begin
            // Load the shadow register; mask to its width, drop spare indexes
            if (cfg_bus.valid && cfg_bus.ready)
            begin
                case (cfg_bus.index)
                    REG_PROP_GAIN:    kp_shadow = cfg_bus.data[GAIN_W-1:0];
                    REG_DERIV_GAIN:   kd_shadow = cfg_bus.data[GAIN_W-1:0];
                    REG_INTEG_GAIN:   ki_shadow = cfg_bus.data[GAIN_W-1:0];
                    REG_ERROR_BOUND:  eb_shadow = cfg_bus.data[BOUND_W-1:0];
                    REG_TORQUE_LIMIT: tl_shadow = cfg_bus.data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // Predict the result of each accepted sample item
            if (sample_bus.valid && sample_bus.ready)
            begin
                got.measured_angle = sample_bus.measured_angle;
                got.desired_angle  = sample_bus.desired_angle;
                got.desired_rate   = sample_bus.desired_rate;
                got.drain_first    = 1'b0;
                expected_torques.push_back(predict_torque(got));
            end
            // Compare each accepted result item with the oldest expectation
            if (result_bus.valid && result_bus.ready)
            begin
                if (expected_torques.size() == 0)
                begin
                    $error("result item with no expectation: torque %0d, integ_cleared %0b",
                           result_bus.torque, result_bus.integ_cleared);
                    fail_count++;
                end
                else
                begin
                    want = expected_torques.pop_front();
                    if (result_bus.torque !== want.torque)
                    begin
                        $error("torque mismatch: expected %0d, actual %0d",
                               want.torque, result_bus.torque);
                        fail_count++;
                    end
                    if (result_bus.integ_cleared !== want.integ_cleared)
                    begin
                        $error("integ_cleared mismatch: expected %0b, actual %0b",
                               want.integ_cleared, result_bus.integ_cleared);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Driver: present the next pending item at the falling edge once the
    // previous one is accepted; insert idle bursts between items
    always @(negedge clk)
    begin : drive_samples
        sample_t next_item;
        if (rst_n && (!sample_bus.valid || sample_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap         <= send_gap - 1;
                sample_bus.valid <= 1'b0;
            end
            else if (pending_samples.size() == 0 ||
                     (pending_samples[0].drain_first && expected_torques.size() != 0))
            begin
                // Hold: nothing to send, or wait for every result to drain
                sample_bus.valid <= 1'b0;
            end
            else
            begin
                next_item = pending_samples.pop_front();
                sample_bus.measured_angle <= next_item.measured_angle;
                sample_bus.desired_angle  <= next_item.desired_angle;
                sample_bus.desired_rate   <= next_item.desired_rate;
                sample_bus.valid          <= 1'b1;
                if (idle_on && $urandom_range(0, 3) == 0)
                    send_gap <= $urandom_range(1, 6);
            end
        end
    end

    // Result sink: stall in random bursts while idling is enabled
    always @(negedge clk)
    begin : drive_ready
        if (rst_n)
        begin
            if (stall_left > 0)
            begin
                stall_left       <= stall_left - 1;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0)
                    stall_left <= $urandom_range(1, 6);
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Queue one sample item, truncating to the field widths
    function automatic void push_sample(input int meas, input int want, input int rate,
                                        input bit drain);
        sample_t s;
        s.measured_angle = meas[ANGLE_W-1:0];
        s.desired_angle  = want[ANGLE_W-1:0];
        s.desired_rate   = rate[RATE_W-1:0];
        s.drain_first    = drain;
        pending_samples.push_back(s);
    endfunction

    // Write one register over the config channel and wait for the handshake
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= val;
        do
            @(negedge clk);
        while (!cfg_taken);
        cfg_bus.valid <= 1'b0;
    endtask

    // Wait until every item is sent and every result is back, then let the
    // pipeline run out before touching the registers
    task automatic settle();
        while (pending_samples.size() != 0 || sample_bus.valid || expected_torques.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin : run_test
        int                 track;
        int                 want;
        int                 span;
        int                 pick;
        int                 p;
        int                 n;
        bit                 drain;
        logic [GAIN_W-1:0]  kp_v;
        logic [GAIN_W-1:0]  kd_v;
        logic [GAIN_W-1:0]  ki_v;
        logic [BOUND_W-1:0] eb_v;
        logic [LIMIT_W-1:0] tl_v;

        // Drive every input to a known value from time zero
        rst_n                     = 1'b0;
        sample_bus.valid          = 1'b0;
        sample_bus.measured_angle = '0;
        sample_bus.desired_angle  = '0;
        sample_bus.desired_rate   = '0;
        result_bus.ready          = 1'b0;
        cfg_bus.valid             = 1'b0;
        cfg_bus.index             = '0;
        cfg_bus.data              = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        idle_on <= 1'b1;

        // Directed items on the reset gains. The first one sees a zeroed
        // angle register; then the full-scale angle jumps saturate the raw rate.
        push_sample(100, 150, 0, 1'b0);
        push_sample(100, 150, 0, 1'b0);
        push_sample(100, 150, 4096, 1'b0);
        push_sample(32767, -32768, 524287, 1'b0);
        push_sample(-32768, 32767, -524288, 1'b0);
        // Error right at the bound, both signs, then one past it
        push_sample(0, 205, 0, 1'b0);
        push_sample(0, -205, 0, 1'b0);
        push_sample(0, 206, 0, 1'b0);
        push_sample(0, 0, 0, 1'b0);
        push_sample(0, 0, 0, 1'b0);
        push_sample(50, 60, 0, 1'b0);
        push_sample(50, 60, 0, 1'b0);
        settle();

        // All-ones data: each register keeps only its own width. Then hit the
        // spare indexes, which must leave the registers untouched.
        cfg_write(REG_PROP_GAIN, '1);
        cfg_write(REG_DERIV_GAIN, '1);
        cfg_write(REG_INTEG_GAIN, '1);
        cfg_write(REG_ERROR_BOUND, '1);
        cfg_write(REG_TORQUE_LIMIT, '1);
        cfg_write(REG_SPARE_LO, '0);
        cfg_write(REG_SPARE_MID, '0);
        cfg_write(REG_SPARE_HI, '0);
        // Maximum gains drive the torque into saturation both ways
        push_sample(0, 32767, 524287, 1'b0);
        push_sample(-32768, 32767, 524287, 1'b0);
        push_sample(32767, -32768, -524288, 1'b0);
        push_sample(32767, 32767, 0, 1'b0);
        push_sample(0, 1, 0, 1'b0);
        push_sample(0, -1, -1, 1'b0);
        settle();

        // All-zero registers: any nonzero error clears, zero error integrates
        cfg_write(REG_PROP_GAIN, '0);
        cfg_write(REG_DERIV_GAIN, '0);
        cfg_write(REG_INTEG_GAIN, '0);
        cfg_write(REG_ERROR_BOUND, '0);
        cfg_write(REG_TORQUE_LIMIT, '0);
        push_sample(0, 0, 0, 1'b0);
        push_sample(0, 1, 0, 1'b0);
        push_sample(0, 0, 0, 1'b0);
        push_sample(0, 0, 0, 1'b0);
        settle();

        track = 0;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES - 1)
            begin
                // Windup: zero PD, widest bound, constant full-scale error
                // right at the bound, so the integrator grows every item
                idle_on <= 1'b0;
                cfg_write(REG_PROP_GAIN, '0);
                cfg_write(REG_DERIV_GAIN, '0);
                cfg_write(REG_INTEG_GAIN, 19'd1);
                cfg_write(REG_ERROR_BOUND, 19'd32767);
                cfg_write(REG_TORQUE_LIMIT, '0);
                for (n = 0; n < WINDUP_ITEMS; n++)
                    push_sample(-16384, 16383, 0, 1'b0);
                push_sample(0, 0, 0, 1'b0);
                push_sample(16383, -16384, 0, 1'b0);
                push_sample(16383, -16384, 0, 1'b0);
                settle();
            end

            // Pick this phase's register setting; the first one is the reset set
            if (p == 0)
            begin
                kp_v = 16'd12800;
                kd_v = 16'd512;
                ki_v = 16'd400;
                eb_v = 15'd205;
                tl_v = 19'd20480;
            end
            else
            begin
                kp_v = GAIN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 8192));
                kd_v = GAIN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 2048));
                ki_v = GAIN_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                           : $urandom_range(0, 1000));
                eb_v = BOUND_W'(($urandom_range(0, 1) == 0) ? $urandom_range(50, 3000)
                                                            : $urandom_range(0, 32767));
                tl_v = LIMIT_W'(($urandom_range(0, 1) == 0) ? $urandom_range(5000, 200000)
                                                            : $urandom_range(0, 524287));
            end
            // Put junk in the unused upper data bits of the narrow registers
            cfg_write(REG_PROP_GAIN, {3'($urandom_range(0, 7)), kp_v});
            cfg_write(REG_DERIV_GAIN, {3'($urandom_range(0, 7)), kd_v});
            cfg_write(REG_INTEG_GAIN, {3'($urandom_range(0, 7)), ki_v});
            cfg_write(REG_ERROR_BOUND, {4'($urandom_range(0, 15)), eb_v});
            cfg_write(REG_TORQUE_LIMIT, tl_v);
            // No idling in one middle phase and in the last one
            idle_on <= (p != 2) && (p != RANDOM_PHASES - 1);

            span = int'(eb_v) + 20;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick  = $urandom_range(0, 99);
                // Hold one item mid-phase in phase 1, and random items, until every result is back
                drain = (p == 1 && n == ITEMS_PER_PHASE / 2) || ($urandom_range(0, 39) == 0);
                if (pick < 70)
                begin
                    // Smooth motion: small steps, error straddling the bound
                    track += int'($urandom_range(0, 80)) - 40;
                    if (track > 32767)
                        track = 32767;
                    if (track < -32768)
                        track = -32768;
                    want = track + int'($urandom_range(0, 2 * span)) - span;
                    if (want > 32767)
                        want = 32767;
                    if (want < -32768)
                        want = -32768;
                    push_sample(track, want, int'($urandom_range(0, 40000)) - 20000, drain);
                end
                else if (pick < 85)
                begin
                    // Noise: every field at full random range
                    push_sample($urandom, $urandom, $urandom, drain);
                end
                else
                begin
                    // Broken trajectory: the angle jumps, tracking resumes from there
                    track = int'($urandom_range(0, 65535)) - 32768;
                    want  = track + int'($urandom_range(0, 200)) - 100;
                    if (want > 32767)
                        want = 32767;
                    if (want < -32768)
                        want = -32768;
                    push_sample(track, want, $urandom, drain);
                end
            end
            settle();
        end

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
